// File: design/bbs_pkg.sv
// Shared types, codes and saturation helpers for the bouncing ball tick engine.
package bbs_pkg;

  // Command codes.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TIME_STEP   = 3'd0;
  localparam logic [2:0] CFG_BALL_COUNT  = 3'd1;
  localparam logic [2:0] CFG_BALL_RADIUS = 3'd2;
  localparam logic [2:0] CFG_WALL_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_FLOOR_LEVEL = 3'd4;
  localparam logic [2:0] CFG_GRAVITY     = 3'd5;

  localparam int CFG_DATA_W = 25;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         ball_index;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_vx;
    logic signed [31:0] in_vy;
  } bbs_req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_vx;
    logic signed [31:0] out_vy;
    logic               status;
  } bbs_rsp_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } ball_t;

  localparam int BALL_W = $bits(ball_t);

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_TG, ST_TL, ST_TL2,
    ST_MV_RD, ST_MV_LD, ST_MV_MX, ST_MV_MY, ST_MV_WR,
    ST_C_RDI, ST_C_LDI, ST_C_RDJ, ST_C_LDJ, ST_C_DIFF, ST_C_TEST,
    ST_C_SQX, ST_C_SQY, ST_C_D2, ST_C_CMP, ST_C_NORM,
    ST_C_M1, ST_C_M2, ST_C_M3, ST_C_M4, ST_C_M5, ST_C_CL,
    ST_C_T1, ST_C_T2, ST_C_T3, ST_C_NEXT, ST_C_WRI
  } bbs_state_t;

  typedef enum logic [1:0] {
    NP_IDLE, NP_ROOT, NP_DIVX, NP_DIVY
  } bbs_nphase_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(S32_MAX)) r = S32_MAX;
    else if (v < 64'(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] neg32(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == S32_MIN) r = S32_MAX;
    else r = -v;
    return r;
  endfunction

endpackage

// File: design/bbs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module bbs_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/bbs_norm.sv
// Unit normal of a ball pair: iterative integer root, then two restoring divisions.
module bbs_norm (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [22:0] dx,
  input  logic signed [22:0] dy,
  input  logic [43:0]        d2,
  output logic               done,
  output logic signed [17:0] nx,
  output logic signed [17:0] ny
);
  import bbs_pkg::*;

  bbs_nphase_t phase, phase_next;

  logic [43:0]        rv;
  logic [44:0]        res;
  logic [43:0]        rbit;
  logic signed [22:0] sdx, sdy;
  logic [21:0]        len;
  logic [37:0]        dvd;
  logic [21:0]        rem;
  logic [16:0]        q;
  logic [5:0]         cnt;

  logic [44:0] trial;
  logic        root_ge;
  logic [44:0] res_nx;
  logic [43:0] rv_nx;
  logic [22:0] rem_t;
  logic        div_ge;
  logic [21:0] rem_nx;
  logic [16:0] q_nx;
  logic [21:0] mag_x, mag_y;
  logic [22:0] neg_dx, neg_dy;

  // One root bit per cycle, same recurrence as the classic digit-by-digit method.
  assign trial   = res + {1'b0, rbit};
  assign root_ge = {1'b0, rv} >= trial;
  assign res_nx  = root_ge ? (res >> 1) + {1'b0, rbit} : (res >> 1);
  assign rv_nx   = root_ge ? rv - trial[43:0] : rv;

  assign rem_t  = {rem, dvd[37]};
  assign div_ge = rem_t >= {1'b0, len};
  assign rem_nx = div_ge ? 22'(rem_t - {1'b0, len}) : rem_t[21:0];
  assign q_nx   = {q[15:0], div_ge};

  assign neg_dx = -sdx;
  assign neg_dy = -sdy;
  assign mag_x  = sdx[22] ? neg_dx[21:0] : sdx[21:0];
  assign mag_y  = sdy[22] ? neg_dy[21:0] : sdy[21:0];

  always_comb begin
    phase_next = phase;
    case (phase)
      NP_IDLE: if (start) phase_next = NP_ROOT;
      NP_ROOT: if (rbit[0]) phase_next = NP_DIVX;
      NP_DIVX: if (cnt == 6'd0) phase_next = NP_DIVY;
      NP_DIVY: if (cnt == 6'd0) phase_next = NP_IDLE;
      default: phase_next = NP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= NP_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == NP_DIVY) && (cnt == 6'd0);
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      NP_IDLE: begin
        if (start) begin
          rv   <= d2;
          res  <= '0;
          rbit <= 44'(1) << 42;
          sdx  <= dx;
          sdy  <= dy;
        end
      end
      NP_ROOT: begin
        rv   <= rv_nx;
        res  <= res_nx;
        rbit <= rbit >> 2;
        if (rbit[0]) begin
          len <= res_nx[21:0];
          dvd <= {mag_x, 16'd0};
          rem <= '0;
          q   <= '0;
          cnt <= 6'd37;
        end
      end
      NP_DIVX: begin
        dvd <= dvd << 1;
        rem <= rem_nx;
        q   <= q_nx;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          nx  <= sdx[22] ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});
          dvd <= {mag_y, 16'd0};
          rem <= '0;
          q   <= '0;
          cnt <= 6'd37;
        end
      end
      NP_DIVY: begin
        dvd <= dvd << 1;
        rem <= rem_nx;
        q   <= q_nx;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          ny <= sdy[22] ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});
        end
      end
      default: ;
    endcase
  end
endmodule

// File: design/bouncing_ball_sim_step.sv
// Top level of the bouncing ball tick engine: ball memory, sequencer and datapath.
//
// A request is taken when start is high and busy is low; its response appears
// on rsp with done high for exactly one cycle and cannot be held off. A write,
// an out-of-range access or an unused command answers in the cycle after the
// request is taken, and a read after its ST_RD state. A tick runs ST_TG, ST_TL and
// ST_TL2 for setup, ST_MV_RD to ST_MV_WR per ball; the pair pass runs ST_C_RDI,
// ST_C_LDI and ST_C_WRI for each ball but the last, ST_C_RDJ to ST_C_TEST and
// ST_C_NEXT for each pair i<j, ST_C_SQX to ST_C_CMP for a pair that passes the box
// test, ST_C_NORM to ST_C_CL when it overlaps (the normal unit runs 22 root steps
// and two 38-step divisions) and ST_C_T1 to ST_C_T3 when it is closing. The
// response follows in the cycle after the last step. All ball state sits in one
// memory with a single read port, so every ball access is a separate read cycle.
module bouncing_ball_sim_step #(
  parameter int MAX_BALLS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  bbs_pkg::bbs_req_t                 req,
  output logic                              done,
  output bbs_pkg::bbs_rsp_t                 rsp,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [bbs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bbs_pkg::*;

  localparam int AW = $clog2(MAX_BALLS);
  localparam int CW = $clog2(MAX_BALLS + 1);

  // Configuration.
  logic [15:0] time_step;
  logic [8:0]  ball_count;
  logic [20:0] ball_radius;
  logic [24:0] wall_limit;
  logic [24:0] floor_level;
  logic [24:0] gravity;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= 16'd1311;
      ball_count  <= 9'd0;
      ball_radius <= 21'd65536;
      wall_limit  <= 25'd2555904;
      floor_level <= 25'd65536;
      gravity     <= 25'd642253;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIME_STEP:   time_step   <= cfg_data[15:0];
        CFG_BALL_COUNT:  ball_count  <= cfg_data[8:0];
        CFG_BALL_RADIUS: ball_radius <= cfg_data[20:0];
        CFG_WALL_LIMIT:  wall_limit  <= cfg_data[24:0];
        CFG_FLOOR_LEVEL: floor_level <= cfg_data[24:0];
        CFG_GRAVITY:     gravity     <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  bbs_state_t state, state_next;

  logic [CW-1:0] n_act;
  logic [CW-1:0] i, j;
  logic          ok;

  assign n_act = (32'(ball_count) > 32'(MAX_BALLS)) ? CW'(MAX_BALLS) : CW'(ball_count);
  assign ok    = 32'(req.ball_index) < 32'(n_act);

  // Memory.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BALL_W-1:0] ram_wdata, ram_rdata;
  ball_t             rball;

  assign rball = ball_t'(ram_rdata);

  bbs_ram #(.WIDTH(BALL_W), .DEPTH(MAX_BALLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared multiplier with a registered product.
  logic signed [36:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [62:0] prod;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Datapath registers.
  ball_t              bi, bj;
  logic [24:0]        gdt;
  logic [43:0]        limsq;
  logic signed [31:0] xn;
  logic signed [32:0] dx, dy;
  logic [44:0]        d2;
  logic signed [49:0] acc;
  logic signed [34:0] nv1, nv2;
  logic signed [35:0] diff;
  logic signed [34:0] tx;

  logic               norm_start, norm_done;
  logic signed [17:0] nx, ny;

  bbs_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .dx    (dx[22:0]),
    .dy    (dy[22:0]),
    .d2    (d2[43:0]),
    .done  (norm_done),
    .nx    (nx),
    .ny    (ny)
  );

  // Move pass arithmetic for the write-back cycle.
  logic signed [31:0] yn, vyg, vy_mv, vx_mv;
  logic signed [26:0] wall_s;
  logic signed [25:0] floor_s;

  assign wall_s  = $signed({2'b0, wall_limit});
  assign floor_s = $signed({1'b0, floor_level});
  assign yn      = sat32(64'(bi.y) + 64'($signed(prod[48:16])));
  assign vyg     = sat32(64'(bi.vy) - 64'($signed({1'b0, gdt})));
  assign vy_mv   = ((yn < floor_s) && (vyg < 0)) ? neg32(vyg) : vyg;

  always_comb begin
    vx_mv = bi.vx;
    if ((xn < -wall_s) && (bi.vx < 0)) vx_mv = neg32(bi.vx);
    else if ((xn > wall_s) && (bi.vx > 0)) vx_mv = neg32(bi.vx);
  end

  // Pair tests.
  logic signed [33:0] lim_s, dx_e, dy_e;
  logic               far;
  logic               pair_hit;
  logic signed [50:0] nsum;
  logic signed [34:0] ty;
  ball_t              bi_hit, bj_hit;

  assign lim_s = $signed({12'b0, ball_radius, 1'b0});
  assign dx_e  = {dx[32], dx};
  assign dy_e  = {dy[32], dy};
  assign far   = (dx_e >= lim_s) || (-dx_e >= lim_s) || (dy_e >= lim_s) || (-dy_e >= lim_s);
  assign pair_hit = (d2 < {1'b0, limsq}) && (d2 != '0);
  assign nsum  = {acc[49], acc} + {prod[49], prod[49:0]};
  assign ty    = $signed(prod[50:16]);

  always_comb begin
    bi_hit    = bi;
    bj_hit    = bj;
    bi_hit.vx = sat32(64'(bi.vx) + 64'(tx));
    bi_hit.vy = sat32(64'(bi.vy) + 64'(ty));
    bj_hit.vx = sat32(64'(bj.vx) - 64'(tx));
    bj_hit.vy = sat32(64'(bj.vy) - 64'(ty));
  end

  logic [CW-1:0] i_p1, j_p1;
  logic [CW:0]   i_p2;

  assign i_p1 = i + CW'(1);
  assign j_p1 = j + CW'(1);
  assign i_p2 = {1'b0, i} + (CW + 1)'(2);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && (req.cmd == CMD_READ) && ok) state_next = ST_RD;
        else if (start && (req.cmd == CMD_TICK)) state_next = ST_TG;
      end
      ST_RD:    state_next = ST_IDLE;
      ST_TG:    state_next = ST_TL;
      ST_TL:    state_next = ST_TL2;
      ST_TL2:   state_next = (n_act == '0) ? ST_IDLE : ST_MV_RD;
      ST_MV_RD: state_next = ST_MV_LD;
      ST_MV_LD: state_next = ST_MV_MX;
      ST_MV_MX: state_next = ST_MV_MY;
      ST_MV_MY: state_next = ST_MV_WR;
      ST_MV_WR: begin
        if (i_p1 != n_act) state_next = ST_MV_RD;
        else if (n_act < CW'(2)) state_next = ST_IDLE;
        else state_next = ST_C_RDI;
      end
      ST_C_RDI:  state_next = ST_C_LDI;
      ST_C_LDI:  state_next = ST_C_RDJ;
      ST_C_RDJ:  state_next = ST_C_LDJ;
      ST_C_LDJ:  state_next = ST_C_DIFF;
      ST_C_DIFF: state_next = ST_C_TEST;
      ST_C_TEST: state_next = far ? ST_C_NEXT : ST_C_SQX;
      ST_C_SQX:  state_next = ST_C_SQY;
      ST_C_SQY:  state_next = ST_C_D2;
      ST_C_D2:   state_next = ST_C_CMP;
      ST_C_CMP:  state_next = pair_hit ? ST_C_NORM : ST_C_NEXT;
      ST_C_NORM: if (norm_done) state_next = ST_C_M1;
      ST_C_M1:   state_next = ST_C_M2;
      ST_C_M2:   state_next = ST_C_M3;
      ST_C_M3:   state_next = ST_C_M4;
      ST_C_M4:   state_next = ST_C_M5;
      ST_C_M5:   state_next = ST_C_CL;
      ST_C_CL:   state_next = (nv2 < nv1) ? ST_C_T1 : ST_C_NEXT;
      ST_C_T1:   state_next = ST_C_T2;
      ST_C_T2:   state_next = ST_C_T3;
      ST_C_T3:   state_next = ST_C_NEXT;
      ST_C_NEXT: state_next = (j_p1 == n_act) ? ST_C_WRI : ST_C_RDJ;
      ST_C_WRI:  state_next = (i_p2 >= {1'b0, n_act}) ? ST_IDLE : ST_C_RDI;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs: memory port, multiplier operands, response.
  logic     fin;
  bbs_rsp_t rsp_next;

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = i[AW-1:0];
    ram_wdata  = bi;
    ram_raddr  = i[AW-1:0];
    mul_a      = '0;
    mul_b      = '0;
    norm_start = 1'b0;
    fin        = 1'b0;
    rsp_next   = '0;
    case (state)
      ST_IDLE: begin
        ram_waddr = AW'(req.ball_index);
        ram_raddr = AW'(req.ball_index);
        ram_wdata = {req.in_x, req.in_y, req.in_vx, req.in_vy};
        ram_we    = start && (req.cmd == CMD_WRITE) && ok;
        if (start && !((req.cmd == CMD_READ) && ok) && (req.cmd != CMD_TICK)) begin
          fin = 1'b1;
          rsp_next.status = ((req.cmd == CMD_WRITE) || (req.cmd == CMD_READ)) && !ok;
        end
      end
      ST_RD: begin
        fin = 1'b1;
        rsp_next.out_x  = rball.x;
        rsp_next.out_y  = rball.y;
        rsp_next.out_vx = rball.vx;
        rsp_next.out_vy = rball.vy;
      end
      ST_TG: begin
        mul_a = $signed({21'b0, time_step});
        mul_b = $signed({1'b0, gravity});
      end
      ST_TL: begin
        mul_a = $signed({15'b0, ball_radius, 1'b0});
        mul_b = $signed({4'b0, ball_radius, 1'b0});
      end
      ST_TL2: fin = (n_act == '0);
      ST_MV_MX: begin
        mul_a = 37'(bi.vx);
        mul_b = $signed({10'b0, time_step});
      end
      ST_MV_MY: begin
        mul_a = 37'(bi.vy);
        mul_b = $signed({10'b0, time_step});
      end
      ST_MV_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {xn, yn, vx_mv, vy_mv};
        fin       = (i_p1 == n_act) && (n_act < CW'(2));
      end
      ST_C_RDJ: ram_raddr = j[AW-1:0];
      ST_C_SQX: begin
        mul_a = 37'(dx);
        mul_b = dx[25:0];
      end
      ST_C_SQY: begin
        mul_a = 37'(dy);
        mul_b = dy[25:0];
      end
      ST_C_CMP: norm_start = pair_hit;
      ST_C_M1: begin
        mul_a = 37'(bi.vx);
        mul_b = 26'(nx);
      end
      ST_C_M2: begin
        mul_a = 37'(bi.vy);
        mul_b = 26'(ny);
      end
      ST_C_M3: begin
        mul_a = 37'(bj.vx);
        mul_b = 26'(nx);
      end
      ST_C_M4: begin
        mul_a = 37'(bj.vy);
        mul_b = 26'(ny);
      end
      ST_C_T1: begin
        mul_a = 37'(diff);
        mul_b = 26'(nx);
      end
      ST_C_T2: begin
        mul_a = 37'(diff);
        mul_b = 26'(ny);
      end
      ST_C_T3: begin
        ram_we    = 1'b1;
        ram_waddr = j[AW-1:0];
        ram_wdata = bj_hit;
      end
      ST_C_WRI: begin
        ram_we = 1'b1;
        fin    = (i_p2 >= {1'b0, n_act});
      end
      default: ;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      rsp <= rsp_next;
    end
  end

  // Datapath register updates.
  always_ff @(posedge clk) begin
    case (state)
      ST_TL:    gdt <= prod[40:16];
      ST_TL2: begin
        limsq <= prod[43:0];
        i     <= '0;
      end
      ST_MV_LD: bi <= rball;
      ST_MV_MY: xn <= sat32(64'(bi.x) + 64'($signed(prod[48:16])));
      ST_MV_WR: i <= (i_p1 == n_act) ? '0 : i_p1;
      ST_C_LDI: begin
        bi <= rball;
        j  <= i_p1;
      end
      ST_C_LDJ: bj <= rball;
      ST_C_DIFF: begin
        dx <= 33'(bj.x) - 33'(bi.x);
        dy <= 33'(bj.y) - 33'(bi.y);
      end
      ST_C_SQY: d2 <= {1'b0, prod[43:0]};
      ST_C_D2:  d2 <= d2 + {1'b0, prod[43:0]};
      ST_C_M2:  acc <= prod[49:0];
      ST_C_M3:  nv1 <= nsum[50:16];
      ST_C_M4:  acc <= prod[49:0];
      ST_C_M5:  nv2 <= nsum[50:16];
      ST_C_CL:  diff <= {nv2[34], nv2} - {nv1[34], nv1};
      ST_C_T2:  tx <= $signed(prod[50:16]);
      ST_C_T3:  bi <= bi_hit;
      ST_C_NEXT: j <= j_p1;
      ST_C_WRI: i <= i_p1;
      default: ;
    endcase
  end
endmodule

// File: dv/bbs_checker.sv
// Checker for the bouncing ball tick engine: tracks ball state and compares each response.
`timescale 1ns / 1ps
module bbs_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  bbs_pkg::bbs_req_t              req,
  input  logic                           done,
  input  bbs_pkg::bbs_rsp_t              rsp,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [bbs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);
  import bbs_pkg::*;

  localparam int NBALLS = 256;

  longint dt, count, radius, wall, floor_lvl, grav;
  logic signed [31:0] px [NBALLS];
  logic signed [31:0] py [NBALLS];
  logic signed [31:0] pvx [NBALLS];
  logic signed [31:0] pvy [NBALLS];
  bbs_rsp_t expected_rsps [$];

  assign pending = expected_rsps.size();

  function automatic logic signed [31:0] clamp32(input longint v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_comp(input longint d, input longint unsigned len);
    longint unsigned mag;
    longint q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = longint'((mag << 16) / len);
    return (d < 0) ? -q : q;
  endfunction

  function automatic void collide_pair(input int i, input int j);
    longint dx, dy, lim, d2, nx, ny, nv1, nv2, diff, tx, ty;
    longint unsigned len;
    dx = longint'(px[j]) - longint'(px[i]);
    dy = longint'(py[j]) - longint'(py[i]);
    lim = 2 * radius;
    if (dx >= lim || -dx >= lim || dy >= lim || -dy >= lim) return;
    d2 = dx * dx + dy * dy;
    if (d2 >= lim * lim || d2 == 0) return;
    len = root64(d2);
    nx = unit_comp(dx, len);
    ny = unit_comp(dy, len);
    nv1 = (longint'(pvx[i]) * nx + longint'(pvy[i]) * ny) >>> 16;
    nv2 = (longint'(pvx[j]) * nx + longint'(pvy[j]) * ny) >>> 16;
    if (!(nv2 < nv1)) return;
    diff = nv2 - nv1;
    tx = (diff * nx) >>> 16;
    ty = (diff * ny) >>> 16;
    pvx[i] = clamp32(longint'(pvx[i]) + tx);
    pvy[i] = clamp32(longint'(pvy[i]) + ty);
    pvx[j] = clamp32(longint'(pvx[j]) - tx);
    pvy[j] = clamp32(longint'(pvy[j]) - ty);
  endfunction

  function automatic void run_tick();
    int n;
    logic signed [31:0] x, y, vx, vy;
    n = (count > NBALLS) ? NBALLS : int'(count);
    for (int i = 0; i < n; i++) begin
      vx = pvx[i];
      vy = pvy[i];
      x = clamp32(longint'(px[i]) + ((longint'(vx) * dt) >>> 16));
      y = clamp32(longint'(py[i]) + ((longint'(vy) * dt) >>> 16));
      vy = clamp32(longint'(vy) - ((dt * grav) >>> 16));
      if (longint'(y) < floor_lvl && vy < 0) vy = clamp32(-longint'(vy));
      if (longint'(x) < -wall && vx < 0) vx = clamp32(-longint'(vx));
      else if (longint'(x) > wall && vx > 0) vx = clamp32(-longint'(vx));
      px[i] = x;
      py[i] = y;
      pvx[i] = vx;
      pvy[i] = vy;
    end
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        collide_pair(i, j);
  endfunction

  function automatic bbs_rsp_t apply_request(input bbs_req_t r);
    bbs_rsp_t e;
    int n;
    e = '0;
    n = (count > NBALLS) ? NBALLS : int'(count);
    if (r.cmd == CMD_WRITE || r.cmd == CMD_READ) begin
      if (int'(r.ball_index) >= n) begin
        e.status = 1'b1;
      end else if (r.cmd == CMD_WRITE) begin
        px[r.ball_index] = r.in_x;
        py[r.ball_index] = r.in_y;
        pvx[r.ball_index] = r.in_vx;
        pvy[r.ball_index] = r.in_vy;
      end else begin
        e.out_x = px[r.ball_index];
        e.out_y = py[r.ball_index];
        e.out_vx = pvx[r.ball_index];
        e.out_vy = pvy[r.ball_index];
      end
    end else if (r.cmd == CMD_TICK) begin
      run_tick();
    end
    return e;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    bbs_rsp_t e;
    if (rst) begin
      dt <= 1311; count <= 0; radius <= 65536;
      wall <= 2555904; floor_lvl <= 65536; grav <= 642253;
      for (int k = 0; k < NBALLS; k++) begin
        px[k] = 0; py[k] = 0; pvx[k] = 0; pvy[k] = 0;
      end
      expected_rsps.delete();
      errors = 0;
    end else begin
      // Responses are retired before a new request in the same cycle is queued.
      if (done) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: response with no request outstanding, actual %h", $time, rsp);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          check_field("out_x", e.out_x, rsp.out_x);
          check_field("out_y", e.out_y, rsp.out_y);
          check_field("out_vx", e.out_vx, rsp.out_vx);
          check_field("out_vy", e.out_vy, rsp.out_vy);
          check_field("status", 32'(e.status), 32'(rsp.status));
        end
      end
      if (start && !busy) expected_rsps.push_back(apply_request(req));
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIME_STEP:   dt <= longint'(cfg_data[15:0]);
          CFG_BALL_COUNT:  count <= longint'(cfg_data[8:0]);
          CFG_BALL_RADIUS: radius <= longint'(cfg_data[20:0]);
          CFG_WALL_LIMIT:  wall <= longint'(cfg_data[24:0]);
          CFG_FLOOR_LEVEL: floor_lvl <= longint'(cfg_data[24:0]);
          CFG_GRAVITY:     grav <= longint'(cfg_data[24:0]);
          default: ;
        endcase
      end
    end
  end

endmodule

// File: dv/tb_bouncing_ball_sim_step.sv
// Testbench top for the bouncing ball tick engine: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb_bouncing_ball_sim_step;
  import bbs_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int ONE = 65536;

  logic clk, rst, start, busy, done, cfg_we;
  bbs_req_t req;
  bbs_rsp_t rsp;
  logic [2:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int errors, pending;
  int cycles = 0;
  int nballs, rad;
  bit allow_idle;

  bouncing_ball_sim_step u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bbs_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic bbs_req_t mk(input logic [1:0] c, input int idx, input int x,
                                  input int y, input int vx, input int vy);
    bbs_req_t r;
    r.cmd = c; r.ball_index = idx[7:0];
    r.in_x = x; r.in_y = y; r.in_vx = vx; r.in_vy = vy;
    return r;
  endfunction

  // Start stays high between back-to-back requests; it only drops for a gap.
  task automatic send(input bbs_req_t r);
    if (allow_idle && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_regs(input int dt, input int cnt, input int r, input int wall,
                          input int flr, input int grav);
    int v[6];
    v = '{dt, cnt, r, wall, flr, grav};
    for (int k = 0; k < 6; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(k);
      cfg_data <= v[k][CFG_DATA_W-1:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    nballs = (cnt > 256) ? 256 : cnt;
    rad = r;
  endtask

  function automatic int near();
    return int'($urandom_range(0, 4 * rad + 4)) - 2 * rad - 2;
  endfunction

  function automatic int speed();
    return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
  endfunction

  task automatic cluster_write(input int idx);
    send(mk(CMD_WRITE, idx, near(), near() + 3 * rad, speed(), speed()));
  endtask

  task automatic random_phase(input int items);
    int sel;
    for (int k = 0; k < nballs; k++) cluster_write(k);
    for (int k = 0; k < items; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 12)
        send(mk(2'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom,
                $urandom, $urandom, $urandom));
      else if (sel < 45)
        send(mk(CMD_TICK, $urandom_range(0, 255), 0, 0, 0, 0));
      else if (sel < 75)
        send(mk(CMD_READ, $urandom_range(0, nballs), 0, 0, 0, 0));
      else
        cluster_write($urandom_range(0, nballs - 1));
    end
    drain();
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    req = '0; allow_idle = 1'b1; nballs = 0; rad = ONE;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With no balls in use every access is out of range and a tick does nothing.
    send(mk(CMD_READ, 0, 0, 0, 0, 0));
    send(mk(CMD_WRITE, 0, 1, 2, 3, 4));
    send(mk(CMD_TICK, 0, 0, 0, 0, 0));
    send(mk(CMD_SPARE, 7, -1, -1, -1, -1));
    drain();

    set_regs(1311, 4, ONE, 39 * ONE, ONE, 642253);
    send(mk(CMD_WRITE, 0, 0, 5 * ONE, 2 * ONE, 0));
    send(mk(CMD_WRITE, 1, ONE + ONE / 2, 5 * ONE, -2 * ONE, 0));
    send(mk(CMD_WRITE, 3, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
            32'sh7fff_ffff));
    send(mk(CMD_READ, 3, 0, 0, 0, 0));
    send(mk(CMD_WRITE, 2, 20 * ONE, 10 * ONE, ONE, 0));
    send(mk(CMD_TICK, 0, 0, 0, 0, 0));
    for (int k = 0; k < 4; k++) send(mk(CMD_READ, k, 0, 0, 0, 0));
    // Two balls on the same center must be left alone by the pair pass.
    send(mk(CMD_WRITE, 2, 20 * ONE, 10 * ONE, ONE, 0));
    send(mk(CMD_WRITE, 3, 20 * ONE, 10 * ONE, ONE, 0));
    send(mk(CMD_TICK, 0, 0, 0, 0, 0));
    send(mk(CMD_READ, 2, 0, 0, 0, 0));
    send(mk(CMD_READ, 3, 0, 0, 0, 0));
    send(mk(CMD_WRITE, 255, -1, -1, -1, -1));
    send(mk(CMD_READ, 200, 0, 0, 0, 0));
    send(mk(CMD_SPARE, 1, 0, 0, 0, 0));
    send(mk(CMD_READ, 4, 0, 0, 0, 0));
    drain();

    set_regs(65535, 2, 0, 0, 0, 0);
    random_phase(6);
    set_regs(0, 8, 1048576, 16777216, 16777216, 16777216);
    random_phase(10);
    allow_idle = 1'b0;
    set_regs($urandom_range(0, 65535), 6, $urandom_range(ONE / 4, 4 * ONE),
             $urandom_range(0, 40 * ONE), $urandom_range(0, 2 * ONE),
             $urandom_range(0, 20 * ONE));
    random_phase(15);
    allow_idle = 1'b1;
    set_regs(1311, 5, ONE, 39 * ONE, ONE, 642253);
    random_phase(15);
    set_regs($urandom_range(0, 65535), 3, $urandom_range(0, 1048576),
             $urandom_range(0, 16777216), $urandom_range(0, 16777216),
             $urandom_range(0, 16777216));
    random_phase(10);

    // A count above the store size acts as the full store, so the last entry is in range.
    set_regs(1311, 300, ONE, 39 * ONE, ONE, 642253);
    send(mk(CMD_WRITE, 255, -ONE, 3 * ONE, ONE, -ONE));
    send(mk(CMD_READ, 255, 0, 0, 0, 0));
    send(mk(CMD_READ, 0, 0, 0, 0, 0));
    drain();

    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
